### rtl/mars_pkg.sv
// Package of the motion-aware region split: sizes, register indexes, controller
// states and the command and status bundles between controller and datapath.
// Depends on nothing.
package mars_pkg;

   localparam int MaxVertices    = 64;
   localparam int MaxRegions     = 8;
   localparam int CoordBits      = 32;
   localparam int DefaultRegions = 4;
   localparam int ScoreBits      = 48;
   localparam int VIdxBits       = $clog2(MaxVertices);
   localparam int CountBits      = 7;
   localparam int RegionBits     = 4;
   localparam int SquareBits     = 2 * CoordBits;
   localparam int RootBits       = CoordBits;
   localparam int CsrDataBits    = 7;

   typedef enum logic [0:0] {
      CSR_VERTEX_COUNT      = 1'b0,
      CSR_REQUESTED_REGIONS = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISP,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_ROOT_GO,
      ST_ROOT,
      ST_SCORE,
      ST_FINISH,
      ST_MAXS,
      ST_DECIDE,
      ST_DIV,
      ST_EVEN,
      ST_SELS,
      ST_TAKE,
      ST_SEL_CHK,
      ST_SCAN,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic item_load;
      logic disp_calc;
      logic diff_calc;
      logic sq_x;
      logic sq_y;
      logic root_start;
      logic score_write;
      logic finish;
      logic sweep_start;
      logic sweep_run;
      logic sweep_sel;
      logic take_best;
      logic div_start;
      logic div_step;
      logic even_step;
      logic scan_init;
      logic scan_step;
      logic clear_set;
   } dp_cmd_type;

   typedef struct packed {
      logic item_active;
      logic item_first;
      logic vertex_zero;
      logic root_busy;
      logic end_set;
      logic sweep_done;
      logic even_case;
      logic div_done;
      logic even_last;
      logic sel_done;
      logic scan_done;
      logic out_free;
   } dp_status_type;

   // Saturate a value one bit wider than a coordinate to the coordinate range.
   function automatic logic [CoordBits-1:0] sat_coord(input logic [CoordBits:0] v);
      logic [CoordBits-1:0] r;
      if (v[CoordBits] != v[CoordBits-1]) begin
         r = {v[CoordBits], {(CoordBits-1){~v[CoordBits]}}};
      end else begin
         r = v[CoordBits-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/mars_root.sv
// Iterative integer square root, one result bit per cycle.
// Depends on mars_pkg.
module mars_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mars_pkg::SquareBits-1:0] radicand,
   output logic                          busy,
   output logic [mars_pkg::RootBits-1:0] root
);
   import mars_pkg::*;

   logic [SquareBits-1:0] rem_ff, rem_in;
   logic [SquareBits-1:0] res_ff, res_in;
   logic [SquareBits-1:0] bit_ff, bit_in;
   logic [SquareBits-1:0] trial;

   always_comb begin
      trial  = res_ff + bit_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         rem_in = radicand;
         res_in = '0;
         bit_in = {2'b01, {(SquareBits-2){1'b0}}};
      end else if (|bit_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign busy = |bit_ff;
   assign root = res_ff[RootBits-1:0];

endmodule

### rtl/mars_datapath.sv
// Datapath of the region split: configuration, base pose and score memories,
// displacement arithmetic, selection sweeps, even split and the result register.
// Depends on mars_pkg and mars_root.
module mars_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  mars_pkg::csr_index_type           csr_index,
   input  logic [mars_pkg::CsrDataBits-1:0]  csr_write_data,
   input  logic signed [mars_pkg::CoordBits-1:0] req_x_position,
   input  logic signed [mars_pkg::CoordBits-1:0] req_y_position,
   input  logic                              req_last_in_sample,
   input  logic                              req_last_sample,
   input  mars_pkg::dp_cmd_type              cmd,
   output mars_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [5:0]                        rsp_first_index,
   output logic [6:0]                        rsp_end_index,
   output logic                              rsp_last_region,
   output logic                              rsp_motion_split
);
   import mars_pkg::*;

   localparam logic [CountBits-1:0]  VcMax      = CountBits'(MaxVertices);
   localparam logic [CountBits-1:0]  CounterTop = {CountBits{1'b1}};
   localparam logic [RegionBits-1:0] ReqDefault = RegionBits'(DefaultRegions);
   localparam logic [RegionBits-1:0] ReqMax     = RegionBits'(MaxRegions);

   // Configuration.
   logic [CountBits-1:0]  vcount_ff;
   logic [RegionBits-1:0] requested_ff;

   // Item registers.
   logic [CoordBits-1:0] x_ff, y_ff;
   logic                 end_sample_ff, end_set_ff;

   // Base pose memories.
   logic [CoordBits-1:0] base_x_mem [MaxVertices];
   logic [CoordBits-1:0] base_y_mem [MaxVertices];
   logic [CoordBits-1:0] base_rd_x_ff, base_rd_y_ff;

   logic [CoordBits-1:0]  dx_ff, dy_ff, prev_x_ff, prev_y_ff;
   logic [CoordBits-1:0]  ax_ff, ay_ff;
   logic [SquareBits-1:0] sqx_ff, sqy_ff;
   logic [CountBits-1:0]  counter_ff;
   logic [1:0]            flags_ff;

   // Score memory with a valid bit per entry.
   logic [ScoreBits-1:0]   score_mem [MaxVertices];
   logic [MaxVertices-1:0] score_vld_ff;
   logic [ScoreBits-1:0]   score_rd_ff;
   logic                   score_rd_vld_ff;

   // Sweep over the boundaries.
   logic [CountBits-1:0] sw_addr_ff;
   logic                 sw_tag_ff;
   logic [VIdxBits-1:0]  sw_idx_ff;
   logic                 any_ff, best_none_ff;
   logic [VIdxBits-1:0]  best_idx_ff;
   logic [ScoreBits-1:0] best_score_ff;
   logic [RegionBits-1:0] sel_cnt_ff;
   logic [MaxVertices-1:0] taken_ff;

   // Even split and motion scan.
   logic [CountBits-1:0]  q_ff, rem_ff, f_ff, p_ff, first_ff;
   logic [RegionBits-1:0] racc_ff, r_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic [5:0] rsp_first_ff;
   logic [6:0] rsp_end_ff;
   logic       rsp_last_ff, rsp_motion_ff;

   // Combinational.
   logic [CountBits-1:0]  vc_step, vc_emit;
   logic [RegionBits-1:0] req_eff, rc;
   logic [CoordBits-1:0]  dx_calc, dy_calc, ex_calc, ey_calc;
   logic [SquareBits-1:0] radicand;
   logic                  root_busy;
   logic [RootBits-1:0]   mag;
   logic [ScoreBits-1:0]  score_cur, score_new;
   logic [ScoreBits:0]    score_sum;
   logic                  score_rd_en;
   logic [VIdxBits-1:0]   score_rd_addr;
   logic                  sw_issue;
   logic [RegionBits:0]   racc_sum;
   logic                  carry;
   logic [RegionBits-1:0] racc_next;
   logic [CountBits-1:0]  e_even;
   logic                  out_free, even_load, scan_end, scan_taken, scan_load;

   always_comb begin
      vc_step = (vcount_ff > VcMax) ? VcMax : vcount_ff;
      vc_emit = (vc_step == '0) ? CountBits'(1) : vc_step;
      if (requested_ff == '0) begin
         req_eff = ReqDefault;
      end else if (requested_ff > ReqMax) begin
         req_eff = ReqMax;
      end else begin
         req_eff = requested_ff;
      end
      rc = ({{(CountBits-RegionBits){1'b0}}, req_eff} < vc_emit) ? req_eff
           : vc_emit[RegionBits-1:0];
   end

   always_comb begin
      dx_calc = sat_coord({x_ff[CoordBits-1], x_ff}
                          - {base_rd_x_ff[CoordBits-1], base_rd_x_ff});
      dy_calc = sat_coord({y_ff[CoordBits-1], y_ff}
                          - {base_rd_y_ff[CoordBits-1], base_rd_y_ff});
      ex_calc = sat_coord({prev_x_ff[CoordBits-1], prev_x_ff} - {dx_ff[CoordBits-1], dx_ff});
      ey_calc = sat_coord({prev_y_ff[CoordBits-1], prev_y_ff} - {dy_ff[CoordBits-1], dy_ff});
      radicand = sqx_ff + sqy_ff;
      score_cur = score_rd_vld_ff ? score_rd_ff : '0;
      score_sum = {1'b0, score_cur} + (ScoreBits+1)'(mag);
      score_new = score_sum[ScoreBits] ? {ScoreBits{1'b1}} : score_sum[ScoreBits-1:0];
      sw_issue = sw_addr_ff < vc_emit;
      score_rd_en = cmd.disp_calc | (cmd.sweep_run & sw_issue);
      score_rd_addr = cmd.sweep_run ? sw_addr_ff[VIdxBits-1:0] : counter_ff[VIdxBits-1:0];
   end

   mars_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (mag)
   );

   // Even split stepping and motion scan decisions.
   always_comb begin
      out_free   = ~rsp_valid_ff | rsp_ready;
      racc_sum   = {1'b0, racc_ff} + {1'b0, rem_ff[RegionBits-1:0]};
      carry      = racc_sum >= {1'b0, rc};
      racc_next  = carry ? (racc_sum[RegionBits-1:0] - rc) : racc_sum[RegionBits-1:0];
      e_even     = f_ff + q_ff + CountBits'(carry);
      even_load  = cmd.even_step & out_free;
      scan_end   = p_ff == vc_emit;
      scan_taken = taken_ff[p_ff[VIdxBits-1:0]];
      scan_load  = cmd.scan_step & out_free & (scan_end | scan_taken);
   end

   always_comb begin
      status.item_active = counter_ff < vc_step;
      status.item_first  = flags_ff == 2'd0;
      status.vertex_zero = counter_ff == '0;
      status.root_busy   = root_busy;
      status.end_set     = end_set_ff;
      status.sweep_done  = ~sw_tag_ff & ~sw_issue;
      status.even_case   = (rc <= RegionBits'(1)) | (vc_emit <= CountBits'(2))
                           | (flags_ff < 2'd2) | ~any_ff;
      status.div_done    = rem_ff < {{(CountBits-RegionBits){1'b0}}, rc};
      status.even_last   = r_ff == (rc - RegionBits'(1));
      status.sel_done    = sel_cnt_ff == (rc - RegionBits'(1));
      status.scan_done   = cmd.scan_step & out_free & scan_end;
      status.out_free    = out_free;
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.item_load && status.item_active && status.item_first) begin
         base_x_mem[counter_ff[VIdxBits-1:0]] <= req_x_position;
         base_y_mem[counter_ff[VIdxBits-1:0]] <= req_y_position;
      end
      if (cmd.item_load) begin
         base_rd_x_ff <= base_x_mem[counter_ff[VIdxBits-1:0]];
         base_rd_y_ff <= base_y_mem[counter_ff[VIdxBits-1:0]];
      end
      if (cmd.score_write) begin
         score_mem[counter_ff[VIdxBits-1:0]] <= score_new;
      end
      if (score_rd_en) begin
         score_rd_ff <= score_mem[score_rd_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         x_ff <= req_x_position;
         y_ff <= req_y_position;
      end
      if (cmd.disp_calc) begin
         dx_ff <= dx_calc;
         dy_ff <= dy_calc;
      end
      if (cmd.diff_calc) begin
         ax_ff <= ex_calc[CoordBits-1] ? (~ex_calc + CoordBits'(1)) : ex_calc;
         ay_ff <= ey_calc[CoordBits-1] ? (~ey_calc + CoordBits'(1)) : ey_calc;
      end
      if (cmd.sq_x) begin
         sqx_ff <= SquareBits'(ax_ff) * SquareBits'(ax_ff);
      end
      if (cmd.sq_y) begin
         sqy_ff <= SquareBits'(ay_ff) * SquareBits'(ay_ff);
      end
      if (cmd.sweep_run) begin
         sw_idx_ff <= sw_addr_ff[VIdxBits-1:0];
      end
      if (cmd.sweep_run && cmd.sweep_sel && sw_tag_ff && !taken_ff[sw_idx_ff]
          && (best_none_ff || score_cur > best_score_ff)) begin
         best_idx_ff   <= sw_idx_ff;
         best_score_ff <= score_cur;
      end
      if (cmd.div_start) begin
         q_ff    <= '0;
         rem_ff  <= vc_emit;
         f_ff    <= '0;
         racc_ff <= '0;
         r_ff    <= '0;
      end else if (cmd.div_step && !status.div_done) begin
         q_ff   <= q_ff + CountBits'(1);
         rem_ff <= rem_ff - {{(CountBits-RegionBits){1'b0}}, rc};
      end else if (even_load) begin
         f_ff    <= e_even;
         racc_ff <= racc_next;
         r_ff    <= r_ff + RegionBits'(1);
      end
      if (cmd.scan_init) begin
         first_ff <= '0;
      end else if (scan_load && !scan_end) begin
         first_ff <= p_ff;
      end
      if (even_load) begin
         rsp_first_ff  <= f_ff[5:0];
         rsp_end_ff    <= e_even;
         rsp_last_ff   <= status.even_last;
         rsp_motion_ff <= 1'b0;
      end else if (scan_load) begin
         rsp_first_ff  <= first_ff[5:0];
         rsp_end_ff    <= scan_end ? vc_emit : p_ff;
         rsp_last_ff   <= scan_end;
         rsp_motion_ff <= 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff       <= CountBits'(1);
         requested_ff    <= '0;
         end_sample_ff   <= 1'b0;
         end_set_ff      <= 1'b0;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         counter_ff      <= '0;
         flags_ff        <= '0;
         score_vld_ff    <= '0;
         score_rd_vld_ff <= 1'b0;
         sw_addr_ff      <= '0;
         sw_tag_ff       <= 1'b0;
         any_ff          <= 1'b0;
         best_none_ff    <= 1'b1;
         sel_cnt_ff      <= '0;
         taken_ff        <= '0;
         p_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_VERTEX_COUNT:      vcount_ff <= csr_write_data;
               CSR_REQUESTED_REGIONS: requested_ff <= csr_write_data[RegionBits-1:0];
               default: ;
            endcase
         end
         if (cmd.item_load) begin
            end_sample_ff <= req_last_in_sample;
            end_set_ff    <= req_last_sample;
            if (status.item_active && status.item_first) begin
               prev_x_ff <= '0;
               prev_y_ff <= '0;
            end
         end
         if (cmd.diff_calc) begin
            prev_x_ff <= dx_ff;
            prev_y_ff <= dy_ff;
         end
         if (score_rd_en) begin
            score_rd_vld_ff <= score_vld_ff[score_rd_addr];
         end
         if (cmd.score_write) begin
            score_vld_ff[counter_ff[VIdxBits-1:0]] <= 1'b1;
         end
         if (cmd.finish) begin
            if (end_sample_ff || end_set_ff) begin
               counter_ff <= '0;
               if (flags_ff < 2'd2) begin
                  flags_ff <= flags_ff + 2'd1;
               end
            end else if (counter_ff != CounterTop) begin
               counter_ff <= counter_ff + CountBits'(1);
            end
         end
         if (cmd.sweep_start) begin
            sw_addr_ff   <= CountBits'(1);
            sw_tag_ff    <= 1'b0;
            best_none_ff <= 1'b1;
            if (!cmd.sweep_sel) begin
               any_ff <= 1'b0;
            end
         end else if (cmd.sweep_run) begin
            sw_tag_ff <= sw_issue;
            if (sw_issue) begin
               sw_addr_ff <= sw_addr_ff + CountBits'(1);
            end
            if (sw_tag_ff && !cmd.sweep_sel && score_cur != '0) begin
               any_ff <= 1'b1;
            end
            if (sw_tag_ff && cmd.sweep_sel && !taken_ff[sw_idx_ff]) begin
               best_none_ff <= 1'b0;
            end
         end
         if (cmd.div_start) begin
            sel_cnt_ff <= '0;
         end
         if (cmd.take_best) begin
            taken_ff[best_idx_ff] <= 1'b1;
            sel_cnt_ff <= sel_cnt_ff + RegionBits'(1);
         end
         if (cmd.scan_init) begin
            p_ff <= CountBits'(1);
         end else if (cmd.scan_step && !scan_end && (out_free || !scan_taken)) begin
            p_ff <= p_ff + CountBits'(1);
         end
         if (even_load || scan_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear_set) begin
            prev_x_ff    <= '0;
            prev_y_ff    <= '0;
            counter_ff   <= '0;
            flags_ff     <= '0;
            score_vld_ff <= '0;
            taken_ff     <= '0;
            sel_cnt_ff   <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_end_index    = rsp_end_ff;
   assign rsp_last_region  = rsp_last_ff;
   assign rsp_motion_split = rsp_motion_ff;

endmodule

### rtl/mars_ctrl.sv
// Controller of the region split: sequences one input beat through the
// datapath and runs the region selection and emission at the end of a set.
// Depends on mars_pkg.
module mars_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mars_pkg::dp_status_type status,
   output mars_pkg::dp_cmd_type    cmd
);
   import mars_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.item_active && !status.item_first) ? ST_DISP : ST_FINISH;
            end
         end
         ST_DISP:    state_in = ST_DIFF;
         ST_DIFF:    state_in = status.vertex_zero ? ST_FINISH : ST_SQX;
         ST_SQX:     state_in = ST_SQY;
         ST_SQY:     state_in = ST_ROOT_GO;
         ST_ROOT_GO: state_in = ST_ROOT;
         ST_ROOT:    state_in = status.root_busy ? ST_ROOT : ST_SCORE;
         ST_SCORE:   state_in = ST_FINISH;
         ST_FINISH:  state_in = status.end_set ? ST_MAXS : ST_IDLE;
         ST_MAXS:    state_in = status.sweep_done ? ST_DECIDE : ST_MAXS;
         ST_DECIDE:  state_in = status.even_case ? ST_DIV : ST_SELS;
         ST_DIV:     state_in = status.div_done ? ST_EVEN : ST_DIV;
         ST_EVEN: begin
            if (status.out_free && status.even_last) begin
               state_in = ST_CLEAR;
            end
         end
         ST_SELS:    state_in = status.sweep_done ? ST_TAKE : ST_SELS;
         ST_TAKE:    state_in = ST_SEL_CHK;
         ST_SEL_CHK: state_in = status.sel_done ? ST_SCAN : ST_SELS;
         ST_SCAN:    state_in = status.scan_done ? ST_CLEAR : ST_SCAN;
         ST_CLEAR:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
         end
         ST_DISP:    cmd.disp_calc = 1'b1;
         ST_DIFF:    cmd.diff_calc = 1'b1;
         ST_SQX:     cmd.sq_x = 1'b1;
         ST_SQY:     cmd.sq_y = 1'b1;
         ST_ROOT_GO: cmd.root_start = 1'b1;
         ST_ROOT:    ;
         ST_SCORE:   cmd.score_write = 1'b1;
         ST_FINISH: begin
            cmd.finish      = 1'b1;
            cmd.sweep_start = status.end_set;
         end
         ST_MAXS:    cmd.sweep_run = 1'b1;
         ST_DECIDE: begin
            cmd.div_start   = status.even_case;
            cmd.sweep_start = ~status.even_case;
            cmd.sweep_sel   = ~status.even_case;
         end
         ST_DIV:     cmd.div_step = 1'b1;
         ST_EVEN:    cmd.even_step = 1'b1;
         ST_SELS: begin
            cmd.sweep_run = 1'b1;
            cmd.sweep_sel = 1'b1;
         end
         ST_TAKE:    cmd.take_best = 1'b1;
         ST_SEL_CHK: begin
            cmd.scan_init   = status.sel_done;
            cmd.sweep_start = ~status.sel_done;
            cmd.sweep_sel   = ~status.sel_done;
         end
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_CLEAR:   cmd.clear_set = 1'b1;
         default:    ;
      endcase
   end

endmodule

### rtl/motion_aware_region_split.sv
// Top level of the motion-aware region split: controller plus datapath.
// Depends on mars_pkg, mars_ctrl and mars_datapath (with mars_root).
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     x, y position, last_in_sample, last_sample
//   rsp      out        rsp_valid / rsp_ready     first_index, end_index, last_region,
//                                                 motion_split
//   csr      in         csr_write_enable          csr_index, csr_write_data
//
// A beat of the first sample, or one beyond the vertex count, goes straight to the
// finish step. A later beat at vertex 0 skips the square root; any other later beat
// waits on the bit-serial square root unit. The beat that ends a set adds one sweep
// over the score memory to find whether any motion was seen. The even split then
// emits its regions; the motion split takes a decision step, one selection sweep per
// chosen split, a scan and a clearing step; stalls on rsp come on top.
// Reset is synchronous and active high; the score memory needs no clearing pass
// as each entry carries a valid bit. A stalled rsp beat holds the emission only;
// the last beat of a set may wait in the output register while new req beats are
// taken.
module motion_aware_region_split (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mars_pkg::CoordBits-1:0] req_x_position,
   input  logic signed [mars_pkg::CoordBits-1:0] req_y_position,
   input  logic                                  req_last_in_sample,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [5:0]                            rsp_first_index,
   output logic [6:0]                            rsp_end_index,
   output logic                                  rsp_last_region,
   output logic                                  rsp_motion_split,
   input  logic                                  csr_write_enable,
   input  mars_pkg::csr_index_type               csr_index,
   input  logic [mars_pkg::CsrDataBits-1:0]      csr_write_data
);
   import mars_pkg::*;

   // Commands from the controller and status back from the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   mars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds every store of the block but the controller state, including the result register.
   mars_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_x_position     (req_x_position),
      .req_y_position     (req_y_position),
      .req_last_in_sample (req_last_in_sample),
      .req_last_sample    (req_last_sample),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_index    (rsp_first_index),
      .rsp_end_index      (rsp_end_index),
      .rsp_last_region    (rsp_last_region),
      .rsp_motion_split   (rsp_motion_split)
   );

endmodule
